// File: sv/qts_pkg.sv
package qts_pkg;

	localparam int unsigned MAX_LINE_LEN = 255;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [6:0] MAX_TOKENS_RESET = 7'd8;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_UNCLOSED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} beat_t;

	typedef struct packed {
		logic [7:0] pos;
		logic       tok_open;
		logic [7:0] open_start;
		logic [7:0] open_len;
		logic [7:0] started;
		logic       in_quote;
		logic       line_fin;
	} scan_state_t;

	typedef struct packed {
		logic       valid;
		logic       token_valid;
		logic [7:0] token_start;
		logic [7:0] token_length;
		logic       line_done;
		status_t    line_status;
		logic [7:0] token_count;
	} result_t;

endpackage

// File: sv/qts_in_reg.sv
module qts_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    char_code,
	input  logic          last_char,
	input  logic          adv,
	output logic          valid_s1,
	output qts_pkg::beat_t beat_s1
);

	logic          vld_s1;
	qts_pkg::beat_t data_s1;

	// hold the beat while the scanner cannot retire it
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1.char_code <= char_code;
			data_s1.last_char <= last_char;
		end
	end

	assign valid_s1 = vld_s1;
	assign beat_s1  = data_s1;

endmodule

// File: sv/qts_scan.sv
module qts_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  qts_pkg::beat_t   beat_s1,
	input  logic [6:0]       max_tokens,
	input  logic             out_ready,
	output logic             adv,
	output qts_pkg::result_t res
);

	qts_pkg::scan_state_t st_q;
	qts_pkg::scan_state_t st_nx;

	always_comb begin
		logic       opens;
		logic       over;
		logic       done;
		logic       emit;
		logic [7:0] es;
		logic [7:0] el;
		logic       is_sep;
		logic [7:0] c;
		logic       last;

		c      = beat_s1.char_code;
		last   = beat_s1.last_char;
		st_nx  = st_q;
		opens  = 1'b0;
		over   = 1'b0;
		done   = 1'b0;
		emit   = 1'b0;
		es     = 8'd0;
		el     = 8'd0;
		is_sep = (c == qts_pkg::CH_SPACE) || (c == qts_pkg::CH_DOT);
		res    = '0;

		if (st_q.line_fin) begin
			// drop bytes until the buffer's last byte
			if (last) begin
				st_nx.line_fin = 1'b0;
			end
		end else begin
			if (c == qts_pkg::CH_NUL) begin
				done = 1'b1;
			end else begin
				if (is_sep && !st_q.in_quote) begin
					if (st_q.tok_open) begin
						emit = 1'b1;
						es   = st_q.open_start;
						el   = st_q.open_len;
					end
					st_nx.tok_open = 1'b0;
				end else if (c == qts_pkg::CH_QUOTE) begin
					st_nx.in_quote = !st_q.in_quote;
					if (st_q.in_quote) begin
						if (st_q.tok_open) begin
							emit = 1'b1;
							es   = st_q.open_start;
							el   = st_q.open_len + 8'd1;
						end
						st_nx.tok_open = 1'b0;
					end else begin
						opens = 1'b1;
					end
				end else if (!st_q.tok_open) begin
					opens = 1'b1;
				end
				if (opens) begin
					st_nx.tok_open   = 1'b1;
					st_nx.open_start = st_q.pos;
					st_nx.open_len   = 8'd0;
					st_nx.started    = st_q.started + 8'd1;
					over = st_nx.started > {1'b0, max_tokens};
				end
				if (st_nx.tok_open) begin
					st_nx.open_len = st_nx.open_len + 8'd1;
				end
				st_nx.pos = st_q.pos + 8'd1;
				if (over || last || (st_nx.pos >= 8'(qts_pkg::MAX_LINE_LEN))) begin
					done = 1'b1;
				end
			end

			if (done) begin
				if (over) begin
					res.line_status = st_nx.in_quote ? qts_pkg::STATUS_UNCLOSED
						: qts_pkg::STATUS_OVERFLOW;
				end else begin
					if (st_nx.tok_open) begin
						emit = 1'b1;
						es   = st_nx.open_start;
						el   = st_nx.open_len;
					end
					res.line_status = st_nx.in_quote ? qts_pkg::STATUS_UNCLOSED
						: qts_pkg::STATUS_OK;
				end
				res.token_count  = st_nx.started;
				st_nx.pos        = 8'd0;
				st_nx.tok_open   = 1'b0;
				st_nx.open_start = 8'd0;
				st_nx.open_len   = 8'd0;
				st_nx.started    = 8'd0;
				st_nx.in_quote   = 1'b0;
				st_nx.line_fin   = !last;
			end
		end

		res.valid        = emit || done;
		res.token_valid  = emit;
		res.token_start  = es;
		res.token_length = el;
		res.line_done    = done;
	end

	// a beat with no result retires even when the output is blocked
	assign adv = valid_s1 && (!res.valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nx;
		end
	end

endmodule

// File: sv/quoted_token_splitter_core.sv
// A byte is registered in qts_in_reg; its scanned result is registered in out_q.
// Throughput: one byte per cycle unless out_stall holds a result, set by the scan step on st_q.
// A byte that gives no result retires without waiting for the output side.
// Reset (arst_n low, asynchronous): pipeline empty, no line open, max_tokens back to 8.
module quoted_token_splitter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       token_valid,
	output logic [7:0] token_start,
	output logic [7:0] token_length,
	output logic       line_done,
	output logic [1:0] line_status,
	output logic [7:0] token_count,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	logic [6:0]       max_tok_q;
	logic             valid_s1;
	qts_pkg::beat_t   beat_s1;
	logic             adv;
	logic             out_ready;
	qts_pkg::result_t res;
	logic             out_valid_q;
	qts_pkg::result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tok_q <= qts_pkg::MAX_TOKENS_RESET;
		end else if (cfg_we) begin
			max_tok_q <= cfg_wdata;
		end
	end

	qts_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1)
	);

	assign out_ready = !out_valid_q || !out_stall;

	qts_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1),
		.max_tokens (max_tok_q),
		.out_ready  (out_ready),
		.adv        (adv),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign token_valid  = out_q.token_valid;
	assign token_start  = out_q.token_start;
	assign token_length = out_q.token_length;
	assign line_done    = out_q.line_done;
	assign line_status  = out_q.line_status;
	assign token_count  = out_q.token_count;

endmodule

// File: sv/qts_checker.sv
module qts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       token_valid,
	input logic [7:0] token_start,
	input logic [7:0] token_length,
	input logic       line_done,
	input logic [1:0] line_status,
	input logic [7:0] token_count
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_valid)
			&& $stable(token_start) && $stable(token_length) && $stable(line_done)
			&& $stable(line_status) && $stable(token_count))
		else $error("result beat changed while stalled");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_valid || line_done)
		else $error("result beat carries neither token nor line end");

	a_no_token_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !token_valid |-> token_start == 8'd0 && token_length == 8'd0)
		else $error("token fields set without a token");

	a_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> line_status == 2'd0 && token_count == 8'd0)
		else $error("line fields set before line end");

	a_token_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_valid |-> token_length != 8'd0 && line_status != 2'd3)
		else $error("empty token or bad status reported");

endmodule

bind quoted_token_splitter_core qts_checker u_qts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.token_valid  (token_valid),
	.token_start  (token_start),
	.token_length (token_length),
	.line_done    (line_done),
	.line_status  (line_status),
	.token_count  (token_count)
);
